FILE: rtl/core/tscc_pkg.sv
`default_nettype none

package tscc_pkg;

  // Widths of the header fields that the checker looks at, of a table entry and of the error counts.
  localparam int PID_W   = 13;
  localparam int CC_W    = 4;
  localparam int ENTRY_W = CC_W + 1;
  localparam int CNT_W   = 32;

  // Number of PIDs tracked for each stream.
  localparam int PID_COUNT = 1 << PID_W;

  localparam int STREAMS_DEFAULT = 4;

  // The null PID carries stuffing and is never tracked.
  localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;

  // Bit of header byte 3 that flags a payload.
  localparam int PAYLOAD_BIT = 4;

  // Bit of a table entry that marks a stored counter.
  localparam int ENTRY_VALID_BIT = CC_W;

  typedef struct packed {
    logic [1:0] stream;
    logic [7:0] header_b1;
    logic [7:0] header_b2;
    logic [7:0] header_b3;
  } in_item_t;

  typedef struct packed {
    logic             cc_error;
    logic             first_seen;
    logic             null_packet;
    logic [CNT_W-1:0] error_total;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/ts_continuity_counter_check.sv
// Transport stream continuity counter checker.
//
// Each input item carries header bytes 1 to 3 of one transport packet and
// the index of the stream it belongs to, and gives exactly one result item:
// the continuity error flag, the first-seen flag, the null packet flag and
// the stream's saturating error count after this packet.
//
// Both channels use valid and stall; an item moves at a rising edge where
// valid is high and stall is low. An accepted item passes the check stage
// and then the output register, from which its result drives out_data.
// One item per cycle is sustained while the receiver does not stall: the
// per-PID table is a single RAM with a registered read, read as an item
// is accepted and written back as it leaves the check stage; a write to
// the entry that the next item has just read is forwarded past the RAM.
//
// After reset the table is swept to zero, one entry per cycle, while
// in_stall stays high; the error counts clear at once. When the receiver
// stalls, the result holds in the output register, one further item may
// wait in the check stage, and then in_stall rises.
// Items for a stream index not below STREAMS touch no state and give zeros.

`default_nettype none

module ts_continuity_counter_check #(
  parameter int STREAMS = tscc_pkg::STREAMS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tscc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tscc_pkg::out_item_t      out_data
);

  import tscc_pkg::*;

  localparam int DEPTH  = STREAMS * PID_COUNT;
  localparam int AW     = $clog2(DEPTH);
  localparam int SIDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Table sweep after reset.
  logic          clearing_r, clearing_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Decode of the incoming header.
  logic [PID_W-1:0] in_pid;
  logic [AW-1:0]    in_addr;
  logic             in_fire;

  // Check stage: the item whose table entry is being read.
  logic             s1_v_r;
  logic [1:0]       s1_stream_r;
  logic [AW-1:0]    s1_addr_r;
  logic [CC_W-1:0]  s1_cc_r;
  logic             s1_pay_r;
  logic             s1_null_r;
  logic             s1_ok_r;
  logic             s1_fire;

  // Forwarding of the write made in the cycle the next item was read.
  logic               fwd_hit_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  // Table port signals.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // Check logic.
  logic [ENTRY_W-1:0] entry;
  logic [CC_W-1:0]    prev_cc;
  logic               tracked;
  logic               item_wr;
  logic               chk_first;
  logic               chk_err;
  logic [SIDX_W-1:0]  s1_sidx;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   cnt_new;

  logic [CNT_W-1:0] err_cnt_r [STREAMS];

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------
  assign in_pid  = {in_data.header_b1[PID_W-9:0], in_data.header_b2};
  // Entry address is the stream index above the PID; the upper bits are
  // dropped only for stream indexes that are ignored anyway.
  assign in_addr = AW'({in_data.stream, in_pid});

  // The check stage moves on when the output register is free or leaving.
  assign s1_fire  = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_v_r && !s1_fire);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
        // The table read done at this edge misses the write done at the
        // same edge, so that write is kept aside for the next check.
        fwd_hit_r <= item_wr && (s1_addr_r == in_addr);
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_stream_r <= in_data.stream;
      s1_addr_r   <= in_addr;
      s1_cc_r     <= in_data.header_b3[CC_W-1:0];
      s1_pay_r    <= in_data.header_b3[PAYLOAD_BIT];
      s1_null_r   <= (in_pid == NULL_PID);
      s1_ok_r     <= (int'(in_data.stream) < STREAMS);
      fwd_data_r  <= ram_wdata;
    end
  end

  // ------------------------------------------------------------------
  // Per-PID table
  // ------------------------------------------------------------------
  assign item_wr   = s1_fire && s1_ok_r && !s1_null_r;
  assign ram_we    = clearing_r || item_wr;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clearing_r ? '0 : {1'b1, s1_cc_r};

  tscc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_pid_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Continuity check and error counting
  // ------------------------------------------------------------------
  assign entry   = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign prev_cc = entry[CC_W-1:0];
  assign tracked = s1_ok_r && !s1_null_r;
  assign s1_sidx = SIDX_W'(s1_stream_r);

  always_comb begin
    chk_first = tracked && !entry[ENTRY_VALID_BIT];
    // A repeated counter is a legal duplicate packet.
    chk_err   = tracked && entry[ENTRY_VALID_BIT] && s1_pay_r &&
                (s1_cc_r != prev_cc) && (s1_cc_r != (prev_cc + CC_W'(1)));
    cnt_cur   = s1_ok_r ? err_cnt_r[s1_sidx] : '0;
    cnt_new   = cnt_cur;
    if (chk_err && (cnt_cur != '1)) begin
      cnt_new = cnt_cur + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STREAMS; i++) begin
        err_cnt_r[i] <= '0;
      end
    end else if (s1_fire && chk_err) begin
      err_cnt_r[s1_sidx] <= cnt_new;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.cc_error    <= chk_err;
      out_data_r.first_seen  <= chk_first;
      out_data_r.null_packet <= s1_ok_r && s1_null_r;
      out_data_r.error_total <= cnt_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) clearing_r |-> in_stall
  ) else $error("item accepted during the table sweep");

  a_stage_holds : assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_fire) |=> (s1_v_r && $stable(s1_addr_r) && $stable(fwd_hit_r))
  ) else $error("check stage lost its item while blocked");

  a_forward_taken : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_fire && item_wr && (s1_addr_r == in_addr)) |=> fwd_hit_r
  ) else $error("write to the entry just read was not forwarded");

  a_result_flags : assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.cc_error &&
                      (out_data_r.first_seen || out_data_r.null_packet))
  ) else $error("continuity error reported with first-seen or null flag");

endmodule

`default_nettype wire

FILE: rtl/core/tscc_ram.sv
`default_nettype none

module tscc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
